>>> hdl/tbc_pkg.sv
//------------------------------------------------------------------------------
// tbc_pkg
// Shared types and constants for the barycentric weight core.
//------------------------------------------------------------------------------
package tbc_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF = 16;
	localparam int LIMIT_BITS = 20;
	localparam int W_BITS = 32;
	localparam logic [1:0] ADDR_LIMIT = 2'd0;

	typedef struct packed {
		logic signed [COORD_BITS_DEF-1:0] point_x;
		logic signed [COORD_BITS_DEF-1:0] point_y;
		logic signed [COORD_BITS_DEF-1:0] vert1_x;
		logic signed [COORD_BITS_DEF-1:0] vert1_y;
		logic signed [COORD_BITS_DEF-1:0] vert2_x;
		logic signed [COORD_BITS_DEF-1:0] vert2_y;
		logic signed [COORD_BITS_DEF-1:0] vert3_x;
		logic signed [COORD_BITS_DEF-1:0] vert3_y;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] weight1;
		logic signed [31:0] weight2;
		logic signed [31:0] weight3;
		logic               degenerate;
	} out_item_t;

endpackage

>>> hdl/tbc_div_cell.sv
//------------------------------------------------------------------------------
// tbc_div_cell
// One restoring-division step for two quotients sharing a divisor; registers
// the partial remainders and passes the carried item to the next cell.
//------------------------------------------------------------------------------
module tbc_div_cell #(
	parameter int DW = 26,
	parameter int QW = 48,
	parameter int NW = 48,
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  logic [DW-1:0] den_in,
	input  logic [DW:0]   r1_in,
	input  logic [DW:0]   r2_in,
	input  logic [NW-1:0] n1_in,
	input  logic [NW-1:0] n2_in,
	input  logic [QW-1:0] q1_in,
	input  logic [QW-1:0] q2_in,
	input  logic [1:0]    neg_in,
	input  logic          dg_in,
	output logic          vld_q,
	output logic [DW-1:0] den_q,
	output logic [DW:0]   r1_q,
	output logic [DW:0]   r2_q,
	output logic [NW-1:0] n1_q,
	output logic [NW-1:0] n2_q,
	output logic [QW-1:0] q1_q,
	output logic [QW-1:0] q2_q,
	output logic [1:0]    neg_q,
	output logic          dg_q
);
	logic [DW+1:0] t1, t2, d1, d2;

	always_comb begin
		t1 = {r1_in, n1_in[NW-1-STEP]};
		t2 = {r2_in, n2_in[NW-1-STEP]};
		d1 = t1 - {2'b00, den_in};
		d2 = t2 - {2'b00, den_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (en) vld_q <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q <= den_in;
			n1_q <= n1_in;
			n2_q <= n2_in;
			neg_q <= neg_in;
			dg_q <= dg_in;
			r1_q <= d1[DW+1] ? t1[DW:0] : d1[DW:0];
			r2_q <= d2[DW+1] ? t2[DW:0] : d2[DW:0];
			q1_q <= {q1_in[QW-2:0], ~d1[DW+1]};
			q2_q <= {q2_in[QW-2:0], ~d2[DW+1]};
		end
	end
endmodule

>>> hdl/tbc_front.sv
//------------------------------------------------------------------------------
// tbc_front
// Edge vectors and cross products, degenerate test, operand magnitudes.
// Two register stages.
//------------------------------------------------------------------------------
module tbc_front #(
	parameter int CB = 12,
	parameter int DW = 26,
	parameter int NW = 48,
	parameter int FB = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  logic [CB-1:0] px, py, x1, y1, x2, y2, x3, y3,
	input  logic [19:0]   limit,
	output logic          vld_s2,
	output logic [DW-1:0] den_s2,
	output logic [NW-1:0] n1_s2,
	output logic [NW-1:0] n2_s2,
	output logic [1:0]    neg_s2,
	output logic          dg_s2
);
	import tbc_pkg::*;
	localparam int EW = CB + 1;
	localparam int PW = 2 * EW + 1;

	logic signed [EW-1:0] ax, ay, bx, by, cx, cy;
	logic signed [PW-1:0] p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1;
	logic                 vld_s1;
	logic signed [PW-1:0] cr, w1n, w2n;
	logic [PW-1:0]        ucr, u1, u2;
	logic [2*PW-1:0]      sq;
	logic                 dg;

	always_comb begin
		ax = EW'(signed'(x1)) - EW'(signed'(x3));
		ay = EW'(signed'(y1)) - EW'(signed'(y3));
		bx = EW'(signed'(x2)) - EW'(signed'(x3));
		by = EW'(signed'(y2)) - EW'(signed'(y3));
		cx = EW'(signed'(px)) - EW'(signed'(x3));
		cy = EW'(signed'(py)) - EW'(signed'(y3));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= PW'(ax * by);
			p1_s1 <= PW'(ay * bx);
			p2_s1 <= PW'(cx * by);
			p3_s1 <= PW'(cy * bx);
			p4_s1 <= PW'(ax * cy);
			p5_s1 <= PW'(ay * cx);
		end
	end

	always_comb begin
		cr = p0_s1 - p1_s1;
		w1n = p2_s1 - p3_s1;
		w2n = p4_s1 - p5_s1;
		ucr = cr[PW-1] ? PW'(-cr) : PW'(cr);
		u1 = w1n[PW-1] ? PW'(-w1n) : PW'(w1n);
		u2 = w2n[PW-1] ? PW'(-w2n) : PW'(w2n);
		sq = ucr * ucr;
		dg = (sq <= (2*PW)'(limit));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s2 <= DW'(ucr);
			n1_s2 <= NW'(u1) << FB;
			n2_s2 <= NW'(u2) << FB;
			neg_s2 <= {w2n[PW-1] ^ cr[PW-1], w1n[PW-1] ^ cr[PW-1]};
			dg_s2 <= dg;
		end
	end
endmodule

>>> hdl/triangle_barycentric_coordinates_core.sv
//------------------------------------------------------------------------------
// triangle_barycentric_coordinates_core
// Structure: 46 register stages (2 front, 43 divider cells, 1 output), at default
// parameters. Throughput: one transfer per cycle while no held result stalls; the
// whole chain advances when the output register is free or being taken.
// Divider: one quotient bit per cell.
// Reset clears valids and limit_q to 0.
//------------------------------------------------------------------------------
module triangle_barycentric_coordinates_core
	import tbc_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [1:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  tbc_pkg::in_item_t     in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output tbc_pkg::out_item_t    out_data
);
	localparam int COORD_BITS = COORD_BITS_DEF;
	localparam int PW = 2 * (COORD_BITS + 1) + 1;
	localparam int DW = PW;
	localparam int NW = PW + FRAC_BITS;
	localparam int QW = NW;
	localparam int NC = NW;

	logic [19:0] limit_q;
	logic        en;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_LIMIT) ? {12'd0, limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= '0;
		else if (psel && penable && pwrite && paddr == ADDR_LIMIT) limit_q <= pwdata[19:0];
	end

	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	logic          v_s2;
	logic [DW-1:0] den_s2;
	logic [NW-1:0] n1_s2, n2_s2;
	logic [1:0]    neg_s2;
	logic          dg_s2;

	tbc_front #(.CB(COORD_BITS), .DW(DW), .NW(NW), .FB(FRAC_BITS)) u_front (
		.clk, .arst_n, .en, .vld_in(in_valid),
		.px(in_data.point_x[COORD_BITS-1:0]), .py(in_data.point_y[COORD_BITS-1:0]),
		.x1(in_data.vert1_x[COORD_BITS-1:0]), .y1(in_data.vert1_y[COORD_BITS-1:0]),
		.x2(in_data.vert2_x[COORD_BITS-1:0]), .y2(in_data.vert2_y[COORD_BITS-1:0]),
		.x3(in_data.vert3_x[COORD_BITS-1:0]), .y3(in_data.vert3_y[COORD_BITS-1:0]),
		.limit(limit_q), .vld_s2(v_s2), .den_s2, .n1_s2, .n2_s2, .neg_s2, .dg_s2
	);

	logic          c_v   [NC+1];
	logic [DW-1:0] c_den [NC+1];
	logic [DW:0]   c_r1  [NC+1];
	logic [DW:0]   c_r2  [NC+1];
	logic [NW-1:0] c_n1  [NC+1];
	logic [NW-1:0] c_n2  [NC+1];
	logic [QW-1:0] c_q1  [NC+1];
	logic [QW-1:0] c_q2  [NC+1];
	logic [1:0]    c_ng  [NC+1];
	logic          c_dg  [NC+1];

	assign c_v[0] = v_s2;
	assign c_den[0] = den_s2;
	assign c_r1[0] = '0;
	assign c_r2[0] = '0;
	assign c_n1[0] = n1_s2;
	assign c_n2[0] = n2_s2;
	assign c_q1[0] = '0;
	assign c_q2[0] = '0;
	assign c_ng[0] = neg_s2;
	assign c_dg[0] = dg_s2;

	for (genvar i = 0; i < NC; i++) begin : g_cell
		tbc_div_cell #(.DW(DW), .QW(QW), .NW(NW), .STEP(i)) u_cell (
			.clk, .arst_n, .en,
			.vld_in(c_v[i]), .den_in(c_den[i]), .r1_in(c_r1[i]), .r2_in(c_r2[i]),
			.n1_in(c_n1[i]), .n2_in(c_n2[i]), .q1_in(c_q1[i]), .q2_in(c_q2[i]),
			.neg_in(c_ng[i]), .dg_in(c_dg[i]),
			.vld_q(c_v[i+1]), .den_q(c_den[i+1]), .r1_q(c_r1[i+1]), .r2_q(c_r2[i+1]),
			.n1_q(c_n1[i+1]), .n2_q(c_n2[i+1]), .q1_q(c_q1[i+1]), .q2_q(c_q2[i+1]),
			.neg_q(c_ng[i+1]), .dg_q(c_dg[i+1])
		);
	end

	function automatic logic signed [33:0] sat_w(input logic [QW-1:0] q, input logic ng);
		logic signed [33:0] r;
		if (ng) r = (q >= QW'(64'h8000_0000)) ? -34'sd2147483648 : -$signed({1'b0, q[32:0]});
		else    r = (q > QW'(64'h7FFF_FFFF)) ? 34'sd2147483647 : $signed({1'b0, q[32:0]});
		return r;
	endfunction

	logic signed [33:0] w1, w2, w3;
	always_comb begin
		w1 = sat_w(c_q1[NC], c_ng[NC][0]);
		w2 = sat_w(c_q2[NC], c_ng[NC][1]);
		w3 = (34'sd1 <<< FRAC_BITS) - w1 - w2;
		if (w3 > 34'sd2147483647) w3 = 34'sd2147483647;
		else if (w3 < -34'sd2147483648) w3 = -34'sd2147483648;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= c_v[NC];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.degenerate <= c_dg[NC];
			out_data.weight1 <= c_dg[NC] ? 32'sd0 : w1[31:0];
			out_data.weight2 <= c_dg[NC] ? 32'sd0 : w2[31:0];
			out_data.weight3 <= c_dg[NC] ? 32'sd0 : w3[31:0];
		end
	end

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall mismatch");
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |-> out_data.weight1 == 32'sd0)
		else $error("degenerate weight nonzero");
`endif
endmodule
